>>> hdl/spp_pkg.sv
// Package with shared constants and types for the screen projection block.
`timescale 1ns / 1ps
package spp_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  localparam logic [1:0] MODE_LOAD_VIEW = 2'd0;
  localparam logic [1:0] MODE_LOAD_PROJ = 2'd1;
  localparam logic [1:0] MODE_TRANSFORM = 2'd2;
  localparam logic [1:0] MODE_PICK      = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [13:0] WIDTH_RESET  = 14'd1024;
  localparam logic [13:0] HEIGHT_RESET = 14'd768;

  // Divider command from the sequencer to the divide unit.
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

>>> hdl/spp_div.sv
// Bit-serial signed fixed-point divider: (n << FRAC_BITS) / d, saturated.
`timescale 1ns / 1ps
module spp_div #(
  parameter int FRAC_BITS  = spp_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = spp_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spp_pkg::div_ctl_t            ctl,
  input  logic signed [WORD_WIDTH-1:0] num,
  input  logic signed [WORD_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [WORD_WIDTH-1:0] quo,
  output logic                         sat
);
  localparam int NW = WORD_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]       dividend;
  logic [NW-1:0]       q;
  logic [WORD_WIDTH:0] rem;
  logic [WORD_WIDTH:0] ud;
  logic                neg;
  logic [CW-1:0]       count;
  logic                busy;

  logic [WORD_WIDTH+1:0] trial;
  logic [WORD_WIDTH:0]   un;
  logic [NW:0]           sq;
  logic                  over;

  assign trial = {rem, dividend[NW-1]} - {1'b0, ud};
  assign un    = num[WORD_WIDTH-1] ? -{num[WORD_WIDTH-1], num} : {1'b0, num};

  // One quotient bit per cycle, restoring division on magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy     <= 1'b1;
        dividend <= {un[WORD_WIDTH-1:0], {FRAC_BITS{1'b0}}};
        rem      <= '0;
        q        <= '0;
        ud       <= den[WORD_WIDTH-1] ? -{den[WORD_WIDTH-1], den} : {1'b0, den};
        neg      <= num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
        count    <= CW'(NW);
      end else if (busy) begin
        dividend <= dividend << 1;
        if (!trial[WORD_WIDTH+1]) begin
          rem <= trial[WORD_WIDTH:0];
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[WORD_WIDTH-1:0], dividend[NW-1]};
          q   <= {q[NW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the sign and clamp to the word range.
  always_comb begin
    sq   = neg ? -{1'b0, q} : {1'b0, q};
    over = 1'b0;
    quo  = sq[WORD_WIDTH-1:0];
    if (!neg && (q > NW'({1'b0, {(WORD_WIDTH-1){1'b1}}}))) begin
      over = 1'b1;
      quo  = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    end else if (neg && (q > NW'({1'b1, {(WORD_WIDTH-1){1'b0}}}))) begin
      over = 1'b1;
      quo  = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    end
    sat = over;
  end
endmodule

>>> hdl/screen_projection_pick.sv
// Top level: matrix store, shared multiply-accumulate sequencer and pick test.
// A load word gives no result; loads can follow back to back.
// A transform word runs two matrix passes of multiply-accumulate, two serial divides
// (skipped when clip w is zero) and the mapping steps; a pick word adds the pick test.
// The next word is taken the cycle after its result is registered. Synchronous reset
// clears both matrices, radius, out_valid and the state; width and height take defaults.
`timescale 1ns / 1ps
module screen_projection_pick #(
  parameter int FRAC_BITS  = spp_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = spp_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [3:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] mouse_x,
  input  logic signed [31:0] mouse_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               hit,
  output logic               w_was_zero,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int W  = WORD_WIDTH;
  localparam int PW = 2 * W + 4;
  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_ROW, S_DIVX, S_DIVY, S_HALF, S_PIX, S_OUTSAT,
    S_DX, S_DY, S_R2, S_CMP, S_OUT
  } state_t;

  state_t state;
  logic [13:0] scr_w, scr_h;
  logic [30:0] radius;

  logic signed [31:0] entry_sx;
  logic signed [W-1:0] view_m [16];
  logic signed [W-1:0] proj_m [16];
  logic signed [W-1:0] vec [4];
  logic signed [W-1:0] res [4];
  logic signed [PW-1:0] acc;
  logic [1:0] row, col;
  logic       pass;
  logic [2:0] step;
  logic       pick;
  logic       pk_hit;
  logic signed [31:0] mx, my;
  logic signed [W-1:0] nx, ny, tx, ty;
  logic signed [31:0] sx, sy;
  logic [65:0] d2;
  logic [65:0] r2;
  logic sat, wz;

  // Shared multiplier operands.
  logic signed [W:0]     ma, mb;
  logic signed [2*W+1:0] prod;
  logic signed [W-1:0]   mat_e;

  // Rounding and saturation helpers.
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] rnd_sh;
  logic signed [W-1:0]  rnd_sat;
  logic                 rnd_ovf;

  spp_pkg::div_ctl_t   dctl;
  logic                ddone, dsat;
  logic signed [W-1:0] dnum, dq;

  spp_div #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(W)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .num(dnum), .den(res[3]),
    .done(ddone), .quo(dq), .sat(dsat)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mat_e     = pass ? proj_m[{row, col}] : view_m[{row, col}];
  assign prod      = ma * mb;

  // Round a sum at FRAC_BITS, ties upward; clamp_w then clamps it.
  function automatic logic signed [PW-1:0] round_fx(input logic signed [PW-1:0] a);
    logic signed [PW-1:0] t;
    t = a + (PW'(1) <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic ovf_w(input logic signed [PW-1:0] a);
    return (a > PW'(MAXW)) || (a < PW'(MINW));
  endfunction

  function automatic logic signed [W-1:0] clamp_w(input logic signed [PW-1:0] a);
    if (a > PW'(MAXW)) return MAXW;
    if (a < PW'(MINW)) return MINW;
    return a[W-1:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [W-1:0] a);
    logic signed [W+32:0] e;
    e = (W+33)'(a);
    if (e > (W+33)'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (e < (W+33)'(-64'sh8000_0000)) return 32'sh8000_0000;
    return 32'(a);
  endfunction

  function automatic logic ovf32(input logic signed [W-1:0] a);
    return clamp32(a) != 32'(a) || ((W > 32) && (PW'(a) != PW'(clamp32(a))));
  endfunction

  assign rnd_sh  = round_fx(rnd);
  assign rnd_sat = clamp_w(rnd_sh);
  assign rnd_ovf = ovf_w(rnd_sh);

  // Operand selection for the shared multiplier, the divider and the rounding input per step.
  always_comb begin
    ma   = '0;
    mb   = '0;
    rnd  = acc;
    dnum = res[0];
    dctl.start = 1'b0;
    case (state)
      S_MAC: begin
        ma = {mat_e[W-1], mat_e};
        mb = {vec[col][W-1], vec[col]};
      end
      S_DIVX: begin
        dctl.start = (step == 3'd0) && (res[3] != '0);
        dnum = res[0];
      end
      S_DIVY: begin
        dctl.start = (step == 3'd0);
        dnum = res[1];
      end
      S_HALF: begin
        ma  = step[0] ? {ny[W-1], ny} : {nx[W-1], nx};
        mb  = {HALF[W-1], HALF};
        rnd = PW'(prod);
      end
      S_PIX: begin
        ma = step[0] ? {ty[W-1], ty} : {tx[W-1], tx};
        mb = step[0] ? (W+1)'({1'b0, scr_h}) : (W+1)'({1'b0, scr_w});
      end
      S_DX: begin
        ma = (W+1)'(33'(mx) - 33'(sx));
        mb = ma;
      end
      S_DY: begin
        ma = (W+1)'(33'(my) - 33'(sy));
        mb = ma;
      end
      S_R2: begin
        ma = (W+1)'({1'b0, radius});
        mb = ma;
      end
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w  <= spp_pkg::WIDTH_RESET;
      scr_h  <= spp_pkg::HEIGHT_RESET;
      radius <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spp_pkg::REG_WIDTH:  scr_w  <= cfg_data[13:0];
        spp_pkg::REG_HEIGHT: scr_h  <= cfg_data[13:0];
        spp_pkg::REG_RADIUS: radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign entry_sx = entry_value;

  // Sequencer: matrix loads, two matrix passes, divides, mapping and pick.
  always_ff @(posedge clk) begin
    logic signed [W-1:0] v;
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] t2;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        view_m[i] <= '0;
        proj_m[i] <= '0;
      end
    end else begin
      // A word held in the output registers leaves on its handshake unless a new one lands.
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            case (mode)
              spp_pkg::MODE_LOAD_VIEW: view_m[entry_index] <= W'(entry_sx);
              spp_pkg::MODE_LOAD_PROJ: proj_m[entry_index] <= W'(entry_sx);
              default: begin
                vec[0] <= W'(point_x);
                vec[1] <= W'(point_y);
                vec[2] <= W'(point_z);
                vec[3] <= ONE;
                mx     <= mouse_x;
                my     <= mouse_y;
                pick   <= (mode == spp_pkg::MODE_PICK);
                row    <= '0;
                col    <= '0;
                pass   <= 1'b0;
                acc    <= '0;
                sat    <= 1'b0;
                wz     <= 1'b0;
                state  <= S_MAC;
              end
            endcase
          end
        end
        S_MAC: begin
          acc <= acc + PW'(prod);
          col <= col + 2'd1;
          if (col == 2'd3) state <= S_ROW;
        end
        S_ROW: begin
          res[row] <= rnd_sat;
          if (rnd_ovf) sat <= 1'b1;
          acc <= '0;
          if (row == 2'd3) begin
            if (!pass) begin
              for (int i = 0; i < 3; i++) vec[i] <= res[i];
              vec[3] <= rnd_sat;
              pass   <= 1'b1;
              row    <= '0;
              state  <= S_MAC;
            end else begin
              step  <= '0;
              state <= S_DIVX;
            end
          end else begin
            row   <= row + 2'd1;
            state <= S_MAC;
          end
        end
        S_DIVX: begin
          if (res[3] == '0) begin
            wz    <= 1'b1;
            nx    <= res[0];
            ny    <= res[1];
            step  <= '0;
            state <= S_HALF;
          end else if (ddone) begin
            nx <= dq;
            if (dsat) sat <= 1'b1;
            step  <= '0;
            state <= S_DIVY;
          end else begin
            step <= 3'd1;
          end
        end
        S_DIVY: begin
          if (ddone) begin
            ny <= dq;
            if (dsat) sat <= 1'b1;
            step  <= '0;
            state <= S_HALF;
          end else begin
            step <= 3'd1;
          end
        end
        S_HALF: begin
          t = rnd_sh + PW'(HALF);
          v = clamp_w(t);
          if (!step[0]) begin
            if (ovf_w(t)) sat <= 1'b1;
            tx   <= v;
            step <= 3'd1;
          end else begin
            t2 = PW'(ONE) - PW'(v);
            ty <= clamp_w(t2);
            if (ovf_w(t) || ovf_w(t2)) sat <= 1'b1;
            step  <= '0;
            state <= S_PIX;
          end
        end
        S_PIX: begin
          v = clamp_w(PW'(prod));
          if (ovf_w(PW'(prod))) sat <= 1'b1;
          if (!step[0]) begin
            tx   <= v;
            step <= 3'd1;
          end else begin
            ty    <= v;
            state <= S_OUTSAT;
          end
        end
        S_OUTSAT: begin
          sx <= clamp32(tx);
          sy <= clamp32(ty);
          if (ovf32(tx) || ovf32(ty)) sat <= 1'b1;
          d2 <= '0;
          state <= pick ? S_DX : S_OUT;
        end
        S_DX: begin
          d2    <= 66'(prod);
          state <= S_DY;
        end
        S_DY: begin
          d2    <= d2 + 66'(prod);
          state <= S_R2;
        end
        // The squared radius comes from the shared multiplier.
        S_R2: begin
          r2    <= 66'(prod);
          state <= S_CMP;
        end
        S_CMP: begin
          pk_hit <= (d2 <= r2);
          state  <= S_OUT;
        end
        // Publish once the output registers are free or being emptied.
        S_OUT: begin
          if (!out_valid || out_ready) begin
            hit        <= pick && pk_hit;
            screen_x   <= sx;
            screen_y   <= sy;
            w_was_zero <= wz;
            saturated  <= sat;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> test/tb_screen_projection_pick.sv
// Testbench for the screen projection and pick block, checked against a local predictor.
`timescale 1ns / 1ps
module tb_screen_projection_pick;

  localparam int FB = 16;
  localparam logic signed [63:0] ONE_FX  = 64'sd1 << FB;
  localparam logic signed [63:0] HALF_FX = 64'sd1 << (FB - 1);
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] mouse_x;
    logic signed [31:0] mouse_y;
  } word_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               hit;
    logic               w_was_zero;
    logic               saturated;
  } pixel_t;

  // Directed table row: a word plus an optional typed-in result.
  typedef struct {
    word_t  w;
    bit     fixed;
    pixel_t res;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [1:0] mode, cfg_index;
  logic [3:0] entry_index;
  logic signed [31:0] entry_value, point_x, point_y, point_z, mouse_x, mouse_y;
  logic signed [31:0] screen_x, screen_y;
  logic hit, w_was_zero, saturated;
  logic [31:0] cfg_data;

  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic [13:0] vp_width, vp_height;
  logic [30:0] radius;

  pixel_t pixel_q [$];
  int  errors = 0;
  int  out_hold = 0;
  bit  quiet_out = 0;

  screen_projection_pick dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .entry_index(entry_index), .entry_value(entry_value),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .mouse_x(mouse_x), .mouse_y(mouse_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .screen_x(screen_x), .screen_y(screen_y), .hit(hit),
    .w_was_zero(w_was_zero), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // Saturate a wide signed value to 32 bits, flagging any clamp.
  function automatic logic signed [63:0] clamp32(input logic signed [191:0] v,
                                                  inout bit flag);
    if (v > MAX32) begin
      flag = 1;
      return MAX32;
    end
    if (v < MIN32) begin
      flag = 1;
      return MIN32;
    end
    return v[63:0];
  endfunction

  // Round to nearest at the fraction point, ties upward (floor after adding half).
  function automatic logic signed [191:0] round_fx(input logic signed [191:0] v);
    return (v + HALF_FX) >>> FB;
  endfunction

  // Fixed-point quotient truncated toward zero.
  function automatic logic signed [63:0] div_fx(input logic signed [63:0] n,
                                                 input logic signed [63:0] d,
                                                 inout bit flag);
    logic [127:0] un, ud, q;
    logic signed [191:0] sq;
    un = (n < 0 ? -n : n);
    ud = (d < 0 ? -d : d);
    q = (un << FB) / ud;
    sq = {64'd0, q};
    if ((n < 0) != (d < 0)) sq = -sq;
    return clamp32(sq, flag);
  endfunction

  // Row-by-row product of a stored matrix and a four-vector.
  function automatic void apply_matrix(input logic signed [31:0] m [16],
                                       input logic signed [63:0] v [4],
                                       output logic signed [63:0] o [4], inout bit flag);
    logic signed [191:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++)
        acc += 192'(signed'(m[r*4+c])) * 192'(v[c]);
      o[r] = clamp32(round_fx(acc), flag);
    end
  endfunction

  // Expected pixel for a transform or pick word; updates matrices on loads.
  function automatic bit project_word(input word_t w, output pixel_t px);
    logic signed [63:0] p [4], vv [4], clip [4];
    logic signed [63:0] nx, ny, t, u, sx, sy;
    logic signed [127:0] dx, dy;
    logic [127:0] d2, r2;
    bit sat, wz;
    sat = 0;
    wz = 0;
    if (w.mode == spp_pkg::MODE_LOAD_VIEW) begin
      view_m[w.entry_index] = w.entry_value;
      return 0;
    end
    if (w.mode == spp_pkg::MODE_LOAD_PROJ) begin
      proj_m[w.entry_index] = w.entry_value;
      return 0;
    end
    p[0] = w.point_x;
    p[1] = w.point_y;
    p[2] = w.point_z;
    p[3] = ONE_FX;
    apply_matrix(view_m, p, vv, sat);
    apply_matrix(proj_m, vv, clip, sat);
    if (clip[3] == 0) begin
      wz = 1;
      nx = clip[0];
      ny = clip[1];
    end else begin
      nx = div_fx(clip[0], clip[3], sat);
      ny = div_fx(clip[1], clip[3], sat);
    end
    t  = clamp32(round_fx(192'(nx) * HALF_FX) + HALF_FX, sat);
    sx = clamp32(192'(t) * $signed({1'b0, vp_width}), sat);
    u  = clamp32(round_fx(192'(ny) * HALF_FX) + HALF_FX, sat);
    t  = clamp32(192'(ONE_FX) - 192'(u), sat);
    sy = clamp32(192'(t) * $signed({1'b0, vp_height}), sat);
    px.hit = 0;
    if (w.mode == spp_pkg::MODE_PICK) begin
      dx = 128'(w.mouse_x) - 128'(sx);
      dy = 128'(w.mouse_y) - 128'(sy);
      d2 = dx * dx + dy * dy;
      r2 = 128'(radius) * 128'(radius);
      px.hit = (d2 <= r2);
    end
    px.screen_x = sx[31:0];
    px.screen_y = sy[31:0];
    px.w_was_zero = wz;
    px.saturated = sat;
    return 1;
  endfunction

  // Output side: stall bursts and field-by-field comparison.
  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("result with no expectation");
          errors++;
        end else begin
          e = pixel_q.pop_front();
          if (screen_x !== e.screen_x) begin
            $error("screen_x exp %0d got %0d", e.screen_x, screen_x);
            errors++;
          end
          if (screen_y !== e.screen_y) begin
            $error("screen_y exp %0d got %0d", e.screen_y, screen_y);
            errors++;
          end
          if (hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, hit);
            errors++;
          end
          if (w_was_zero !== e.w_was_zero) begin
            $error("w_was_zero exp %0d got %0d", e.w_was_zero, w_was_zero);
            errors++;
          end
          if (saturated !== e.saturated) begin
            $error("saturated exp %0d got %0d", e.saturated, saturated);
            errors++;
          end
        end
      end
      if (quiet_out) begin
        out_ready <= 1'b1;
        out_hold = 0;
      end else if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        out_hold = $urandom_range(0, 14);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Drive one input word and wait for its acceptance.
  task automatic send_word(input word_t w, input bit gaps);
    pixel_t px;
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    mode <= w.mode;
    entry_index <= w.entry_index;
    entry_value <= w.entry_value;
    point_x <= w.point_x;
    point_y <= w.point_y;
    point_z <= w.point_z;
    mouse_x <= w.mouse_x;
    mouse_y <= w.mouse_y;
    do @(posedge clk); while (!in_ready);
    if (project_word(w, px)) pixel_q.push_back(px);
  endtask

  // Register write, only while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    in_valid <= 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == spp_pkg::REG_WIDTH) vp_width = val[13:0];
    else if (idx == spp_pkg::REG_HEIGHT) vp_height = val[13:0];
    else if (idx == spp_pkg::REG_RADIUS) radius = val[30:0];
  endtask

  function automatic logic signed [31:0] rand_fx();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic word_t rand_word();
    word_t w;
    w = '{default: 0};
    w.mode = 2'($urandom_range(0, 3));
    w.entry_index = 4'($urandom_range(0, 15));
    w.entry_value = rand_fx();
    w.point_x = rand_fx();
    w.point_y = rand_fx();
    w.point_z = rand_fx();
    w.mouse_x = rand_fx();
    w.mouse_y = rand_fx();
    return w;
  endfunction

  function automatic word_t mk(input logic [1:0] m, input logic [3:0] i,
                               input logic signed [31:0] v);
    word_t w;
    w = '{default: 0};
    w.mode = m;
    w.entry_index = i;
    w.entry_value = v;
    return w;
  endfunction

  initial begin
    row_t dir [$];
    row_t r;
    word_t w;
    pixel_t px;
    int n;
    in_valid = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    {mode, entry_index, entry_value, point_x, point_y, point_z, mouse_x, mouse_y} = '0;
    for (int i = 0; i < 16; i++) begin
      view_m[i] = 0;
      proj_m[i] = 0;
    end
    vp_width = spp_pkg::WIDTH_RESET;
    vp_height = spp_pkg::HEIGHT_RESET;
    radius = 0;
    rst = 1;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed table. Zero matrices give w zero and the viewport center.
    r.fixed = 1;
    r.w = mk(spp_pkg::MODE_TRANSFORM, 0, 0);
    r.res = '{32'sd512 <<< 16, 32'sd384 <<< 16, 1'b0, 1'b1, 1'b0};
    dir.push_back(r);
    r.w = mk(spp_pkg::MODE_PICK, 0, 0);
    r.w.mouse_x = 32'sd512 <<< 16;
    r.w.mouse_y = 32'sd384 <<< 16;
    r.res = '{32'sd512 <<< 16, 32'sd384 <<< 16, 1'b1, 1'b1, 1'b0};
    dir.push_back(r);
    r.fixed = 0;
    // Identity view and projection, then extreme entries and points.
    for (int i = 0; i < 4; i++) begin
      r.w = mk(spp_pkg::MODE_LOAD_VIEW, 4'(i*5), 32'sh10000);
      dir.push_back(r);
      r.w = mk(spp_pkg::MODE_LOAD_PROJ, 4'(i*5), 32'sh10000);
      dir.push_back(r);
    end
    r.w = mk(spp_pkg::MODE_TRANSFORM, 0, 0);
    r.w.point_x = 32'sh8000;
    r.w.point_y = -32'sh4000;
    dir.push_back(r);
    r.w.point_x = 32'sh7FFFFFFF;
    r.w.point_y = 32'sh80000000;
    r.w.point_z = 32'sh7FFFFFFF;
    dir.push_back(r);
    r.w.mode = spp_pkg::MODE_PICK;
    r.w.mouse_x = 32'sh80000000;
    r.w.mouse_y = 32'sh7FFFFFFF;
    dir.push_back(r);
    r.w = mk(spp_pkg::MODE_LOAD_VIEW, 15, 32'sh80000000);
    dir.push_back(r);
    r.w = mk(spp_pkg::MODE_LOAD_PROJ, 12, 32'sh7FFFFFFF);
    dir.push_back(r);
    r.w = mk(spp_pkg::MODE_PICK, 0, 0);
    r.w.point_x = -32'sh20000;
    dir.push_back(r);

    foreach (dir[k]) begin
      send_word(dir[k].w, 0);
      if (dir[k].fixed) begin
        px = pixel_q.pop_back();
        pixel_q.push_back(dir[k].res);
        if (px !== dir[k].res) begin
          $error("predictor disagrees with table row %0d", k);
          errors++;
        end
      end
    end

    // Random phases through several register settings, extremes included.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(spp_pkg::REG_WIDTH, 32'd1);
          write_reg(spp_pkg::REG_HEIGHT, 32'd8192);
          write_reg(spp_pkg::REG_RADIUS, 32'h7FFFFFFF);
        end
        1: begin
          write_reg(spp_pkg::REG_WIDTH, 32'd8192);
          write_reg(spp_pkg::REG_HEIGHT, 32'd1);
          write_reg(spp_pkg::REG_RADIUS, 32'd0);
        end
        2: begin
          write_reg(spp_pkg::REG_WIDTH, 32'hFFFFFFFF);
          write_reg(spp_pkg::REG_HEIGHT, 32'd0);
          write_reg(spp_pkg::REG_RADIUS, 32'hFFFFFFFF);
        end
        default: begin
          write_reg(spp_pkg::REG_WIDTH, $urandom);
          write_reg(spp_pkg::REG_HEIGHT, $urandom_range(1, 8192));
          write_reg(spp_pkg::REG_RADIUS, $urandom_range(0, 32'h0800_0000));
        end
      endcase
      write_reg(REG_UNUSED, $urandom);
      n = 0;
      while (n < 50) begin
        w = rand_word();
        // Keep matrices small most of the time so results stay on screen.
        if (w.mode <= spp_pkg::MODE_LOAD_PROJ && $urandom_range(0, 3) != 0)
          w.entry_value = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        quiet_out = (ph == 6 && n > 30);
        send_word(w, !quiet_out);
        if (w.mode >= spp_pkg::MODE_TRANSFORM) n++;
      end
    end

    in_valid <= 0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
hdl/spp_pkg.sv
hdl/spp_div.sv
hdl/screen_projection_pick.sv
test/tb_screen_projection_pick.sv
